// ===== rtl/psc_pkg.sv =====
// Shared constants, types and a saturation helper for the point set normalizer.
`default_nettype none
package psc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = 24;
	localparam int SUM_W = 30;
	localparam int DVD_W = 56;
	localparam int REM_W = DVD_W + 1;
	localparam int SC_W = DVD_W / 2;
	localparam int QFRAC = 49;
	localparam int MA_W = SC_W + 1;
	localparam int MB_W = PW + 1;
	localparam int PR_W = MA_W + MB_W;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} it_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [DVD_W-1:0] v);
		logic signed [DVD_W-1:0] hi;
		logic signed [DVD_W-1:0] lo;
		hi = DVD_W'(64'sd2147483647);
		lo = -DVD_W'(64'sd2147483648);
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/psc_store.sv =====
// Point memory: one write port, one registered read port for x and y.
`default_nettype none
module psc_store
	import psc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire logic signed [PW-1:0] wr_x,
	input  wire logic signed [PW-1:0] wr_y,
	input  wire logic [AW-1:0]        rd_addr,
	output logic signed [PW-1:0]      rd_x,
	output logic signed [PW-1:0]      rd_y
);

	logic [2*PW-1:0] mem_q [MAX_POINTS];
	logic [2*PW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_x, wr_y};
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_x = rd_q[2*PW-1:PW];
	assign rd_y = rd_q[PW-1:0];

endmodule
`default_nettype wire

// ===== rtl/psc_iter.sv =====
// Shared bit-serial unit: restoring divide, one bit a cycle, or square root, one digit a cycle.
`default_nettype none
module psc_iter
	import psc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire it_ctl_t          ctl,
	input  wire logic [DVD_W-1:0] dvd,
	input  wire logic [DVD_W-1:0] dvs,
	output logic                  done,
	output logic [DVD_W-1:0]      quo,
	output logic [DVD_W-1:0]      rem
);

	logic             busy_q;
	logic             done_q;
	logic             mode_q;
	logic [5:0]       cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] cand;
	logic [REM_W-1:0] trial;
	logic             ge;

	always_comb begin
		if (mode_q) begin
			cand = {rem_q[REM_W-3:0], dvd_q[DVD_W-1:DVD_W-2]};
			trial = {quo_q[DVD_W-2:0], 2'b01};
		end else begin
			cand = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
			trial = {1'b0, dvs_q};
		end
		ge = cand >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.sqrt_mode ? 6'(SC_W - 1) : 6'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dvd;
			dvs_q <= dvs;
			quo_q <= '0;
			rem_q <= '0;
			mode_q <= ctl.sqrt_mode;
		end else if (busy_q) begin
			rem_q <= ge ? cand - trial : cand;
			quo_q <= {quo_q[DVD_W-2:0], ge};
			dvd_q <= mode_q ? {dvd_q[DVD_W-3:0], 2'b00} : {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q[DVD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/point_set_centre_normalize.sv =====
// Top level: point loading, centroid and spread passes, scale, and the result emit.
//
//  channel  | direction | handshake                  | word
//  point    | in        | point_valid / point_stall  | point_x, point_y, set_end
//  result   | out       | result_valid / result_stall| norm_x .. run_end
//
// A point that does not end the set is taken without a stall.
// After the last point of a set, loading resumes once the set has gone through the bit-serial
// divide/sqrt unit (whose scale steps are skipped when the spread is zero) and one shared multiplier
// reading the point memory.
// Reset clears the count, the sums and all control; the point memory is not cleared.
// A stalled result holds the emit pass; point_stall stays high until the last word of the
// set is in the output register.
`default_nettype none
module point_set_centre_normalize
	import psc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 point_valid,
	output logic                      point_stall,
	input  wire logic signed [PW-1:0] point_x,
	input  wire logic signed [PW-1:0] point_y,
	input  wire logic                 set_end,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic signed [31:0]        norm_x,
	output logic signed [31:0]        norm_y,
	output logic [31:0]               scale_factor,
	output logic signed [31:0]        shift_x,
	output logic signed [31:0]        shift_y,
	output logic                      degenerate,
	output logic                      run_end
);

	localparam logic [4:0] S_LOAD = 5'd0;
	localparam logic [4:0] S_CXGO = 5'd1;
	localparam logic [4:0] S_CXW  = 5'd2;
	localparam logic [4:0] S_CYW  = 5'd3;
	localparam logic [4:0] S_VRD  = 5'd4;
	localparam logic [4:0] S_VMX  = 5'd5;
	localparam logic [4:0] S_VMY  = 5'd6;
	localparam logic [4:0] S_VACC = 5'd7;
	localparam logic [4:0] S_QGO  = 5'd8;
	localparam logic [4:0] S_QW   = 5'd9;
	localparam logic [4:0] S_RW   = 5'd10;
	localparam logic [4:0] S_SHX  = 5'd11;
	localparam logic [4:0] S_SHY  = 5'd12;
	localparam logic [4:0] S_SHS  = 5'd13;
	localparam logic [4:0] S_ERD  = 5'd14;
	localparam logic [4:0] S_EMX  = 5'd15;
	localparam logic [4:0] S_EMY  = 5'd16;
	localparam logic [4:0] S_EOUT = 5'd17;

	logic [4:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           idx_q;
	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;
	logic signed [PW-1:0]    cx_q;
	logic signed [PW-1:0]    cy_q;
	logic [DVD_W-1:0]        v_q;
	logic [SC_W-1:0]         scale_q;
	logic                    degen_q;
	logic signed [31:0]      shx_q;
	logic signed [31:0]      shy_q;
	logic signed [31:0]      nx_q;
	logic signed [PR_W-1:0]  prod_s1;

	logic                    out_valid_q;
	logic signed [31:0]      out_nx_q;
	logic signed [31:0]      out_ny_q;
	logic [31:0]             out_sc_q;
	logic signed [31:0]      out_shx_q;
	logic signed [31:0]      out_shy_q;
	logic                    out_deg_q;
	logic                    out_end_q;

	logic                    accept;
	logic                    wr_en;
	logic signed [PW-1:0]    rd_x;
	logic signed [PW-1:0]    rd_y;
	logic signed [PW:0]      dx;
	logic signed [PW:0]      dy;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	it_ctl_t                 it_ctl;
	logic [DVD_W-1:0]        it_dvd;
	logic [DVD_W-1:0]        it_dvs;
	logic                    it_done;
	logic [DVD_W-1:0]        it_quo;
	logic [DVD_W-1:0]        it_rem;
	logic                    last_idx;
	logic                    out_free;
	logic signed [PW:0]      cent;
	logic signed [SUM_W-1:0] cur_sum;
	logic signed [PR_W:0]    neg_prod;
	logic signed [31:0]      shift_sat;
	logic signed [31:0]      prod_sat;

	assign point_stall = state_q != S_LOAD;
	assign accept = point_valid && !point_stall;
	assign wr_en = accept && (count_q < CW'(MAX_POINTS));
	assign last_idx = idx_q == AW'(count_q - CW'(1));
	assign out_free = !out_valid_q || !result_stall;

	psc_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_x    (point_x),
		.wr_y    (point_y),
		.rd_addr (idx_q),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	psc_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (it_ctl),
		.dvd    (it_dvd),
		.dvs    (it_dvs),
		.done   (it_done),
		.quo    (it_quo),
		.rem    (it_rem)
	);

	always_comb begin
		dx = {rd_x[PW-1], rd_x} - {cx_q[PW-1], cx_q};
		dy = {rd_y[PW-1], rd_y} - {cy_q[PW-1], cy_q};
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_VMX: begin
				mul_a = MA_W'(dx);
				mul_b = dx;
			end
			S_VMY: begin
				mul_a = MA_W'(dy);
				mul_b = dy;
			end
			S_SHX: begin
				mul_a = {1'b0, scale_q};
				mul_b = {cx_q[PW-1], cx_q};
			end
			S_SHY: begin
				mul_a = {1'b0, scale_q};
				mul_b = {cy_q[PW-1], cy_q};
			end
			S_EMX: begin
				mul_a = {1'b0, scale_q};
				mul_b = dx;
			end
			S_EMY, S_EOUT: begin
				mul_a = {1'b0, scale_q};
				mul_b = dy;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		it_ctl.start = 1'b0;
		it_ctl.sqrt_mode = 1'b0;
		it_dvd = '0;
		it_dvs = DVD_W'(count_q);
		unique case (state_q)
			S_CXGO: begin
				it_ctl.start = 1'b1;
				it_dvd = DVD_W'(sum_x_q[SUM_W-1] ? -sum_x_q : sum_x_q);
			end
			S_CXW: begin
				it_ctl.start = it_done;
				it_dvd = DVD_W'(sum_y_q[SUM_W-1] ? -sum_y_q : sum_y_q);
			end
			S_QGO: begin
				it_ctl.start = v_q != '0;
				it_dvd = {count_q, QFRAC'(0)};
				it_dvs = v_q;
			end
			S_QW: begin
				it_ctl.start = it_done;
				it_ctl.sqrt_mode = 1'b1;
				it_dvd = it_quo;
			end
			default: begin
				it_ctl.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		cur_sum = (state_q == S_CXW) ? sum_x_q : sum_y_q;
		if (cur_sum[SUM_W-1]) begin
			cent = -(PW+1)'(it_quo) - ((it_rem != '0) ? (PW+1)'(1) : (PW+1)'(0));
		end else begin
			cent = (PW+1)'(it_quo);
		end
		neg_prod = -{prod_s1[PR_W-1], prod_s1};
		shift_sat = sat32(DVD_W'(neg_prod >>> 8));
		prod_sat = sat32(DVD_W'(prod_s1));
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			idx_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (wr_en) begin
						count_q <= count_q + CW'(1);
						sum_x_q <= sum_x_q + SUM_W'(point_x);
						sum_y_q <= sum_y_q + SUM_W'(point_y);
					end
					if (accept && set_end) begin
						state_q <= S_CXGO;
					end
				end
				S_CXGO: state_q <= S_CXW;
				S_CXW: begin
					if (it_done) begin
						state_q <= S_CYW;
					end
				end
				S_CYW: begin
					if (it_done) begin
						idx_q <= '0;
						state_q <= S_VRD;
					end
				end
				S_VRD: state_q <= S_VMX;
				S_VMX: state_q <= S_VMY;
				S_VMY: state_q <= S_VACC;
				S_VACC: begin
					if (last_idx) begin
						state_q <= S_QGO;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_VRD;
					end
				end
				S_QGO: state_q <= (v_q == '0) ? S_SHX : S_QW;
				S_QW: begin
					if (it_done) begin
						state_q <= S_RW;
					end
				end
				S_RW: begin
					if (it_done) begin
						state_q <= S_SHX;
					end
				end
				S_SHX: state_q <= S_SHY;
				S_SHY: state_q <= S_SHS;
				S_SHS: begin
					idx_q <= '0;
					state_q <= S_ERD;
				end
				S_ERD: state_q <= S_EMX;
				S_EMX: state_q <= S_EMY;
				S_EMY: state_q <= S_EOUT;
				S_EOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (last_idx) begin
							count_q <= '0;
							sum_x_q <= '0;
							sum_y_q <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_q + AW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CXW && it_done) begin
			cx_q <= cent[PW-1:0];
		end
		if (state_q == S_CYW && it_done) begin
			cy_q <= cent[PW-1:0];
		end
		if (state_q == S_CYW) begin
			v_q <= '0;
		end else if (state_q == S_VMY || state_q == S_VACC) begin
			v_q <= v_q + DVD_W'(prod_s1[2*PW-1:0]);
		end
		if (state_q == S_QGO) begin
			degen_q <= v_q == '0;
			scale_q <= '0;
		end
		if (state_q == S_RW && it_done) begin
			scale_q <= it_quo[SC_W-1:0];
		end
		if (state_q == S_SHY) begin
			shx_q <= shift_sat;
		end
		if (state_q == S_SHS) begin
			shy_q <= shift_sat;
		end
		if (state_q == S_EMY) begin
			nx_q <= prod_sat;
		end
		if (state_q == S_EOUT && out_free) begin
			out_nx_q <= nx_q;
			out_ny_q <= prod_sat;
			out_sc_q <= 32'(scale_q);
			out_shx_q <= shx_q;
			out_shy_q <= shy_q;
			out_deg_q <= degen_q;
			out_end_q <= last_idx;
		end
	end

	assign result_valid = out_valid_q;
	assign norm_x = out_nx_q;
	assign norm_y = out_ny_q;
	assign scale_factor = out_sc_q;
	assign shift_x = out_shx_q;
	assign shift_y = out_shy_q;
	assign degenerate = out_deg_q;
	assign run_end = out_end_q;

endmodule
`default_nettype wire

// ===== rtl/psc_checker.sv =====
// Port-level checks for the point set normalizer, bound to the top level.
`default_nettype none
module psc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        point_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [31:0] norm_x,
	input wire logic [31:0] norm_y,
	input wire logic [31:0] scale_factor,
	input wire logic [31:0] shift_x,
	input wire logic [31:0] shift_y,
	input wire logic        degenerate,
	input wire logic        run_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(norm_x))
		else $error("Stalled result word changed.");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> norm_x == 0 && norm_y == 0 && scale_factor == 0
			&& shift_x == 0 && shift_y == 0)
		else $error("Degenerate word carries nonzero terms.");

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !run_end |-> point_stall)
		else $error("Points taken while a set is still being emitted.");

	a_scale_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !run_end ##1 result_valid |-> $stable(scale_factor))
		else $error("Scale changed within a set.");

endmodule

bind point_set_centre_normalize psc_checker u_psc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_stall  (point_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.norm_x       (norm_x),
	.norm_y       (norm_y),
	.scale_factor (scale_factor),
	.shift_x      (shift_x),
	.shift_y      (shift_y),
	.degenerate   (degenerate),
	.run_end      (run_end)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for point_set_centre_normalize: directed and random point sets checked against a scoreboard model.
`default_nettype none
module tb_top
	import psc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic [31:0] scale;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic degen;
		logic last;
	} norm_word_t;

	class norm_scoreboard;
		longint px[$];
		longint py[$];
		longint acc_x, acc_y;
		norm_word_t pending[$];
		int errors;
		int sets_done;
		int degen_sets;
		int full_sets;

		function longint fdiv(longint a, longint b);
			longint q;
			q = a / b;
			if (a % b != 0 && a < 0) q--;
			return q;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_point(logic signed [PW-1:0] x, logic signed [PW-1:0] y, logic fin);
			longint n, cx, cy, dx, dy, shx, shy;
			longint unsigned spread, sc;
			norm_word_t w;
			if (px.size() < MAX_POINTS) begin
				px.push_back(longint'(x));
				py.push_back(longint'(y));
				acc_x += longint'(x);
				acc_y += longint'(y);
			end
			if (!fin) return;
			n = px.size();
			cx = fdiv(acc_x, n);
			cy = fdiv(acc_y, n);
			spread = 0;
			foreach (px[i]) begin
				dx = px[i] - cx;
				dy = py[i] - cy;
				spread += longint'(dx * dx) + longint'(dy * dy);
			end
			sc = 0;
			if (spread != 0) begin
				sc = root(((64'd1 << 49) * n) / spread);
				if (sc > 64'hFFFFFFFF) sc = 64'hFFFFFFFF;
			end
			shx = clip32(fdiv(-(longint'(sc) * cx), 256));
			shy = clip32(fdiv(-(longint'(sc) * cy), 256));
			foreach (px[i]) begin
				if (spread == 0) begin
					w = '{0, 0, 0, 0, 0, 1'b1, 1'b0};
				end else begin
					w.nx = 32'(clip32(longint'(sc) * (px[i] - cx)));
					w.ny = 32'(clip32(longint'(sc) * (py[i] - cy)));
					w.scale = 32'(sc);
					w.sx = 32'(shx);
					w.sy = 32'(shy);
					w.degen = 1'b0;
				end
				w.last = (i == n - 1);
				pending.push_back(w);
			end
			sets_done++;
			if (spread == 0) degen_sets++;
			if (n == MAX_POINTS) full_sets++;
			px.delete();
			py.delete();
			acc_x = 0;
			acc_y = 0;
		endfunction

		function void check_word(norm_word_t got);
			norm_word_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.nx !== e.nx) begin
				$error("norm_x exp %0d got %0d", e.nx, got.nx); errors++;
			end
			if (got.ny !== e.ny) begin
				$error("norm_y exp %0d got %0d", e.ny, got.ny); errors++;
			end
			if (got.scale !== e.scale) begin
				$error("scale_factor exp %0d got %0d", e.scale, got.scale); errors++;
			end
			if (got.sx !== e.sx) begin
				$error("shift_x exp %0d got %0d", e.sx, got.sx); errors++;
			end
			if (got.sy !== e.sy) begin
				$error("shift_y exp %0d got %0d", e.sy, got.sy); errors++;
			end
			if (got.degen !== e.degen) begin
				$error("degenerate exp %0d got %0d", e.degen, got.degen); errors++;
			end
			if (got.last !== e.last) begin
				$error("run_end exp %0d got %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	logic signed [PW-1:0] point_x = '0;
	logic signed [PW-1:0] point_y = '0;
	logic set_end = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] norm_x, norm_y, shift_x, shift_y;
	logic [31:0] scale_factor;
	logic degenerate, run_end;

	norm_scoreboard sb = new();
	int idle_cycles;
	int words_out;
	int points_sent;
	bit feed_done;

	point_set_centre_normalize u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic send_point(logic signed [PW-1:0] x, logic signed [PW-1:0] y, logic fin);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		set_end <= fin;
		do @(posedge clk); while (point_stall);
		sb.note_point(x, y, fin);
		points_sent++;
	endtask

	function automatic logic signed [PW-1:0] pick_coord(int mode, int base);
		case (mode)
			0: return PW'($urandom());
			1: return PW'(base + $signed($urandom_range(0, 64)) - 32);
			2: return ($urandom_range(0, 1)) ? 24'sh7FFFFF : 24'sh800000;
			default: return PW'(base + $signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	task automatic send_set(int n, int mode);
		int bx, by;
		bx = $signed($urandom_range(0, 2000000)) - 1000000;
		by = $signed($urandom_range(0, 2000000)) - 1000000;
		for (int i = 0; i < n; i++) begin
			send_point(pick_coord(mode, bx), pick_coord(mode, by), i == n - 1);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_point(24'sh7FFFFF, 24'sh800000, 1'b1);
		send_point(24'sh7FFFFF, 24'sh800000, 1'b0);
		send_point(24'sh800000, 24'sh7FFFFF, 1'b1);
		send_point(24'sh000100, -24'sd300, 1'b0);
		send_point(24'sh000100, -24'sd300, 1'b0);
		send_point(24'sh000100, -24'sd300, 1'b1);
		send_point(24'sd0, 24'sd0, 1'b0);
		send_point(24'sd1, 24'sd0, 1'b1);
		send_point(-24'sd5, 24'sd7, 1'b0);
		send_point(24'sd4, -24'sd6, 1'b0);
		send_point(24'sh123456, 24'sh654321, 1'b1);
		point_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		@(posedge clk);
		send_set(MAX_POINTS + 3, 0);
		while (points_sent < 230) begin
			send_set($urandom_range(0, 9) == 0 ? $urandom_range(20, 66)
				: $urandom_range(1, 6), $urandom_range(0, 3));
		end
		point_valid <= 1'b0;
		feed_done = 1'b1;
	end

	always @(posedge clk) begin
		norm_word_t w;
		if (result_valid && !result_stall) begin
			w.nx = norm_x;
			w.ny = norm_y;
			w.scale = scale_factor;
			w.sx = shift_x;
			w.sy = shift_y;
			w.degen = degenerate;
			w.last = run_end;
			sb.check_word(w);
			words_out++;
		end
	end

	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else if (result_valid && result_stall == 1'b0) begin
				hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
				result_stall <= (hold > 0);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (result_valid && !result_stall)) idle_cycles = 0;
		else idle_cycles++;
	end

	initial begin
		wait (arst_n);
		fork
			begin
				while (!feed_done || sb.pending.size() != 0) @(posedge clk);
				repeat (200) @(posedge clk);
			end
			begin
				wait (idle_cycles >= 5000);
			end
		join_any
		if (idle_cycles >= 5000) begin
			$display("** point_set_centre_normalize: FAILED **");
		end else begin
			$display("Checked %0d sets (%0d degenerate, %0d full) and %0d result words.",
				sb.sets_done, sb.degen_sets, sb.full_sets, words_out);
			if (sb.errors == 0 && sb.pending.size() == 0) begin
				$display("** point_set_centre_normalize: PASSED **");
			end else begin
				$display("** point_set_centre_normalize: FAILED **");
			end
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/psc_pkg.sv
rtl/psc_store.sv
rtl/psc_iter.sv
rtl/point_set_centre_normalize.sv
rtl/psc_checker.sv
tb/sv/tb_top.sv
